// ===== rtl/mcfr_pkg.sv =====
// mcfr_pkg: shared types and constants for the motor command frame receiver.
// Used by mcfr_frame_core and motor_command_frame_receiver_unit; no dependencies.
package mcfr_pkg;

  localparam logic [7:0] HDR_FRAME   = 8'h48;  // 'H' opens a seven-byte frame
  localparam logic [7:0] HDR_STATUS  = 8'h4F;  // 'O' asks for status
  localparam int         PAYLOAD_LEN = 5;
  localparam int         IDX_W       = 3;
  localparam int         STORE_AW    = $clog2(PAYLOAD_LEN);
  localparam logic [IDX_W-1:0] IDX_IDLE   = 3'd0;
  localparam logic [IDX_W-1:0] IDX_FIRST  = 3'd1;
  localparam logic [IDX_W-1:0] LAST_INDEX = 3'd6;

  typedef enum logic [1:0] {
    KIND_OK       = 2'd0,
    KIND_CSUM_ERR = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_t;

  // One step's outcome, core to top level.
  typedef struct packed {
    logic        has;
    kind_t       kind;
    logic [1:0]  motor_number;
    logic        dir_forward;
    logic        rotation_mode;
    logic [15:0] speed;
    logic [15:0] step_count;
  } result_t;

endpackage

// ===== rtl/mcfr_frame_core.sv =====
// mcfr_frame_core: frame byte counter, running checksum, payload bytes and decode.
// Depends on mcfr_pkg. State advances only on step.
module mcfr_frame_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output mcfr_pkg::result_t      res
);

  logic [mcfr_pkg::IDX_W-1:0]    byte_index;
  logic [mcfr_pkg::IDX_W-1:0]    byte_index_next;
  logic [7:0]                    running_sum;
  logic [7:0]                    running_sum_next;
  logic [7:0]                    payload_store [mcfr_pkg::PAYLOAD_LEN];
  logic                          store_we;
  logic [mcfr_pkg::STORE_AW-1:0] store_addr;
  logic                          sum_ok;

  assign sum_ok = (running_sum == rx_byte);

  always_comb begin
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    store_we         = 1'b0;
    store_addr       = mcfr_pkg::STORE_AW'(byte_index - mcfr_pkg::IDX_FIRST);
    res              = '0;
    res.kind         = mcfr_pkg::KIND_OK;
    if (byte_index == mcfr_pkg::IDX_IDLE) begin
      if (rx_byte == mcfr_pkg::HDR_FRAME) begin
        running_sum_next = rx_byte;
        byte_index_next  = mcfr_pkg::IDX_FIRST;
      end else if (rx_byte == mcfr_pkg::HDR_STATUS) begin
        res.has  = 1'b1;
        res.kind = mcfr_pkg::KIND_STATUS;
      end
    end else if (byte_index == mcfr_pkg::LAST_INDEX) begin
      byte_index_next = mcfr_pkg::IDX_IDLE;
      res.has         = 1'b1;
      if (sum_ok) begin
        res.kind          = mcfr_pkg::KIND_OK;
        res.motor_number  = payload_store[0][7:6];
        res.dir_forward   = ~payload_store[0][5];
        res.rotation_mode = payload_store[0][4];
        res.speed         = {payload_store[2], payload_store[1]};
        res.step_count    = {payload_store[4], payload_store[3]};
      end else begin
        res.kind = mcfr_pkg::KIND_CSUM_ERR;
      end
    end else if (byte_index < mcfr_pkg::LAST_INDEX) begin
      store_we         = 1'b1;
      running_sum_next = running_sum + rx_byte;
      byte_index_next  = byte_index + mcfr_pkg::IDX_FIRST;
    end else begin
      // out-of-range index: drop back to idle, no result
      byte_index_next = mcfr_pkg::IDX_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= mcfr_pkg::IDX_IDLE;
      running_sum <= '0;
    end else if (step) begin
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
    end
  end

  // payload bytes: no reset, always written before read
  always_ff @(posedge clk) begin
    if (step && store_we) begin
      payload_store[store_addr] <= rx_byte;
    end
  end

endmodule

// ===== rtl/motor_command_frame_receiver_unit.sv =====
// motor_command_frame_receiver_unit: top level of the motor command frame receiver.
// Depends on mcfr_pkg and mcfr_frame_core.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | sink      | in_valid / in_stall  | rx_byte
//  out     | source    | out_valid / out_stall| kind, motor_number, dir_forward,
//          |           |                      | rotation_mode, speed, step_count
//
// One byte per cycle while in_stall is low; out_valid for a result rises once its byte
// has moved on from the input register and its result is loaded into the result register.
// Reset clears the byte counter, checksum and both valid flags; payload bytes are
// not reset. When the result register is full and stalled, a byte that would give
// a result waits in the input register and in_stall rises; bytes that give no
// result keep flowing.
module motor_command_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  motor_number,
  output logic        dir_forward,
  output logic        rotation_mode,
  output logic [15:0] speed,
  output logic [15:0] step_count
);

  // input register
  logic              s1_valid;
  logic [7:0]        s1_byte;
  // result register
  mcfr_pkg::result_t out_res;

  mcfr_pkg::result_t core_res;
  logic              out_free;
  logic              s1_go;
  logic              in_take;

  // Result register can load this cycle if empty or being drained.
  assign out_free = ~out_valid | ~out_stall;
  // The held byte moves on unless it has a result with nowhere to go.
  assign s1_go    = s1_valid & (~core_res.has | out_free);
  assign in_stall = s1_valid & ~s1_go;
  assign in_take  = in_valid & ~in_stall;

  mcfr_frame_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .rx_byte (s1_byte),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && core_res.has) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload holds while stalled
  always_ff @(posedge clk) begin
    if (s1_go && core_res.has) begin
      out_res <= core_res;
    end
  end

  assign kind          = out_res.kind;
  assign motor_number  = out_res.motor_number;
  assign dir_forward   = out_res.dir_forward;
  assign rotation_mode = out_res.rotation_mode;
  assign speed         = out_res.speed;
  assign step_count    = out_res.step_count;

endmodule
